/* rtl/sdaf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the signed decimal ASCII formatter.
// Depends on nothing; used by signed_decimal_ascii_formatter.
package sdaf_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int VALUE_W        = 32;
	localparam int CHAR_W         = 8;
	localparam int DIGIT_W        = 4;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	// Decimal digits needed for an unsigned number of the given width.
	// 1233 / 4096 is a close lower bound of log10(2) over the usable range.
	function automatic int digits_for(input int bits);
		return ((bits * 1233) >> 12) + 1;
	endfunction

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

endpackage

/* rtl/signed_decimal_ascii_formatter.sv */
`timescale 1ns / 1ps
// Signed decimal ASCII formatter: one signed integer in, its decimal text out.
// Steps: a load, VALUE_BITS shift-and-add-3 steps, dropping of leading zeros (up to NDIG-1),
// then the sign if negative and one character per cycle while out_ready is high.
// A new value is taken only in idle, once the last character of the previous one is out.
// Reset: arst_n clears the sequencer and the output valid flag asynchronously.
// Depends on sdaf_pkg.
module signed_decimal_ascii_formatter #(
	parameter int VALUE_BITS = sdaf_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [sdaf_pkg::VALUE_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sdaf_pkg::CHAR_W-1:0]       ascii_char,
	output logic                              last_char
);

	// Number of BCD digits held, and the widths of the counters that walk them.
	localparam int NDIG    = sdaf_pkg::digits_for(VALUE_BITS);
	localparam int BCD_W   = NDIG * sdaf_pkg::DIGIT_W;
	localparam int BITC_W  = $clog2(VALUE_BITS);
	localparam int DIGC_W  = $clog2(NDIG + 1);

	sdaf_pkg::state_t state_q, state_d;

	// Conversion datapath. The magnitude shifts out of mag_q, most significant
	// bit first, into the BCD register. Before every shift, each BCD digit of 5
	// or more gets 3 added, so that doubling it carries correctly into the next
	// digit. This one adjust-and-shift unit is reused for all VALUE_BITS steps.
	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;
	logic [BITC_W-1:0]     bit_cnt_q;
	logic [DIGC_W-1:0]     dig_cnt_q;
	logic                  neg_q;

	// The output register parts the sequencer from the consumer.
	logic                          out_valid_q;
	logic [sdaf_pkg::CHAR_W-1:0]   char_q;
	logic                          last_q;

	logic [VALUE_BITS-1:0]           raw;
	logic                            raw_neg;
	logic [sdaf_pkg::DIGIT_W-1:0]    top_digit;
	logic                            out_free;

	// Control strobes from the output decode.
	logic load_item;
	logic conv_step;
	logic skip_step;
	logic put_sign;
	logic put_digit;

	// Bits above VALUE_BITS are ignored; a wider setting zero-extends the port.
	assign raw       = VALUE_BITS'($unsigned(value));
	assign raw_neg   = raw[VALUE_BITS-1];
	assign top_digit = bcd_q[BCD_W-1 -: sdaf_pkg::DIGIT_W];
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*sdaf_pkg::DIGIT_W +: sdaf_pkg::DIGIT_W] >= 4'd5) begin
				bcd_adj[i*sdaf_pkg::DIGIT_W +: sdaf_pkg::DIGIT_W] =
					bcd_q[i*sdaf_pkg::DIGIT_W +: sdaf_pkg::DIGIT_W] + 4'd3;
			end else begin
				bcd_adj[i*sdaf_pkg::DIGIT_W +: sdaf_pkg::DIGIT_W] =
					bcd_q[i*sdaf_pkg::DIGIT_W +: sdaf_pkg::DIGIT_W];
			end
		end
	end

	// Next state. Leading zeros are dropped one digit per cycle, but the last
	// digit always stays, so zero prints as a single '0'.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sdaf_pkg::ST_IDLE: begin
				if (in_valid) state_d = sdaf_pkg::ST_CONV;
			end
			sdaf_pkg::ST_CONV: begin
				if (bit_cnt_q == '0) state_d = sdaf_pkg::ST_SKIP;
			end
			sdaf_pkg::ST_SKIP: begin
				if (!(top_digit == '0 && dig_cnt_q > DIGC_W'(1))) begin
					state_d = neg_q ? sdaf_pkg::ST_SIGN : sdaf_pkg::ST_EMIT;
				end
			end
			sdaf_pkg::ST_SIGN: begin
				if (out_free) state_d = sdaf_pkg::ST_EMIT;
			end
			sdaf_pkg::ST_EMIT: begin
				if (out_free && dig_cnt_q == DIGC_W'(1)) state_d = sdaf_pkg::ST_IDLE;
			end
			default: state_d = sdaf_pkg::ST_IDLE;
		endcase
	end

	// Output decode of the sequencer.
	always_comb begin
		in_ready  = 1'b0;
		load_item = 1'b0;
		conv_step = 1'b0;
		skip_step = 1'b0;
		put_sign  = 1'b0;
		put_digit = 1'b0;
		unique case (state_q)
			sdaf_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				load_item = in_valid;
			end
			sdaf_pkg::ST_CONV: begin
				conv_step = 1'b1;
			end
			sdaf_pkg::ST_SKIP: begin
				skip_step = (top_digit == '0) && (dig_cnt_q > DIGC_W'(1));
			end
			sdaf_pkg::ST_SIGN: begin
				put_sign = out_free;
			end
			sdaf_pkg::ST_EMIT: begin
				put_digit = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sdaf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (put_sign || put_digit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers; they carry no reset.
	always_ff @(posedge clk) begin
		if (load_item) begin
			// The magnitude of the most negative value is correct as an
			// unsigned number, so no overflow case arises.
			mag_q     <= raw_neg ? (~raw + VALUE_BITS'(1)) : raw;
			neg_q     <= raw_neg;
			bcd_q     <= '0;
			bit_cnt_q <= BITC_W'(VALUE_BITS - 1);
		end
		if (conv_step) begin
			{bcd_q, mag_q} <= {bcd_adj[BCD_W-2:0], mag_q, 1'b0};
			bit_cnt_q      <= bit_cnt_q - BITC_W'(1);
			dig_cnt_q      <= DIGC_W'(NDIG);
		end
		if (skip_step || put_digit) begin
			bcd_q     <= {bcd_q[BCD_W-sdaf_pkg::DIGIT_W-1:0], {sdaf_pkg::DIGIT_W{1'b0}}};
			dig_cnt_q <= dig_cnt_q - DIGC_W'(1);
		end
		if (put_sign) begin
			char_q <= sdaf_pkg::CHAR_MINUS;
			last_q <= 1'b0;
		end
		if (put_digit) begin
			char_q <= sdaf_pkg::CHAR_ZERO | {{(sdaf_pkg::CHAR_W-sdaf_pkg::DIGIT_W){1'b0}}, top_digit};
			last_q <= (dig_cnt_q == DIGC_W'(1));
		end
	end

	assign out_valid  = out_valid_q;
	assign ascii_char = char_q;
	assign last_char  = last_q;

endmodule
